// File: rtl/ntc_pkg.sv
// Shared types, constants and the fixed resistance table for the NTC temperature block.
`default_nettype none

package ntc_pkg;

  // Fixed field widths
  localparam int ADC_W      = 10;
  localparam int RES_W      = 16;
  localparam int TEMP_W     = 9;
  localparam int ST_W       = 2;
  localparam int LIMIT_W    = 10;
  localparam int OFFSET_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TBL_IDX_W  = 8;   // index width of the table function (up to 256 entries)
  localparam int FIXED_N    = 100;
  localparam int FIXED_IDX_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd2;

  // Configuration reset values
  localparam logic [RES_W-1:0]    REF_RST    = 16'd24000;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 10'd1000;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 7'd9;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FAULT = 2'd1;
  localparam logic [ST_W-1:0] ST_BELOW = 2'd2;
  localparam logic [ST_W-1:0] ST_ABOVE = 2'd3;

  // Special temperature codes
  localparam logic signed [TEMP_W-1:0] TEMP_FAULT = 9'sd160;
  localparam logic signed [TEMP_W-1:0] TEMP_BELOW = -9'sd99;
  localparam logic signed [TEMP_W-1:0] TEMP_ABOVE = 9'sd150;

  localparam logic [RES_W-1:0] RES_MAX = 16'hFFFF;

  // Thermistor resistance in ohms for table indexes 0 to 99, descending
  localparam logic [RES_W-1:0] FIXED_TBL [FIXED_N] = '{
    16'd28017, 16'd26826, 16'd25697, 16'd24629, 16'd23618,
    16'd22660, 16'd21752, 16'd20892, 16'd20075, 16'd19299,
    16'd18560, 16'd18482, 16'd18149, 16'd17632, 16'd16992,
    16'd16280, 16'd15535, 16'd14787, 16'd14055, 16'd13354,
    16'd12690, 16'd12068, 16'd11490, 16'd10954, 16'd10458,
    16'd10000, 16'd9576,  16'd9184,  16'd8819,  16'd8478,
    16'd8160,  16'd7861,  16'd7579,  16'd7311,  16'd7056,
    16'd6813,  16'd6581,  16'd6357,  16'd6142,  16'd5934,
    16'd5734,  16'd5541,  16'd5353,  16'd5173,  16'd4998,
    16'd4829,  16'd4665,  16'd4507,  16'd4355,  16'd4208,
    16'd4065,  16'd3927,  16'd3794,  16'd3664,  16'd3538,
    16'd3415,  16'd3294,  16'd3175,  16'd3058,  16'd2941,
    16'd2825,  16'd2776,  16'd2718,  16'd2652,  16'd2582,
    16'd2508,  16'd2432,  16'd2356,  16'd2280,  16'd2207,
    16'd2135,  16'd2066,  16'd2000,  16'd1938,  16'd1879,
    16'd1823,  16'd1770,  16'd1720,  16'd1673,  16'd1628,
    16'd1586,  16'd1546,  16'd1508,  16'd1471,  16'd1435,
    16'd1401,  16'd1367,  16'd1334,  16'd1301,  16'd1268,
    16'd1236,  16'd1204,  16'd1171,  16'd1139,  16'd1107,
    16'd1074,  16'd1042,  16'd1010,  16'd979,   16'd948
  };

  // Table entry; positions past the fixed contents read as zero
  function automatic logic [RES_W-1:0] tbl_entry(input logic [TBL_IDX_W-1:0] idx);
    logic [RES_W-1:0] val;
    val = '0;
    if (idx < TBL_IDX_W'(FIXED_N)) begin
      val = FIXED_TBL[idx[FIXED_IDX_W-1:0]];
    end
    return val;
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // take the accepted sample
    logic mul;        // form product and divisor
    logic prep;       // fault / saturation decision, load divider
    logic div_step;   // one quotient bit
    logic range_chk;  // table range check, search init
    logic probe;      // one binary search probe
    logic load_out;   // load the result register
  } ntc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fault;
    logic sat;
    logic range_ok;
    logic srch_done;
  } ntc_stat_t;

endpackage

`default_nettype wire

// File: rtl/ntc_thermistor_temperature.sv
// Top level of the NTC thermistor ADC-to-temperature converter.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_adc_sample
//   out      output     out_valid / out_stall out_temperature, out_resistance_ohms, out_status
//   cfg      input      cfg_wr_en             cfg_index, cfg_wdata
//
// A request on a sensor fault goes from the product straight to the result; otherwise it runs
// the bit-per-cycle divider, the table range check and, when in range, a binary search of at
// most floor(log2(TABLE_DEPTH))+1 probes (7 for the 100-entry table) before the result.
// A saturated resistance skips the divider.
// Synchronous active-low reset; configuration comes up at its reset values.
// A held result waits in the output register while the next request is worked on; that
// request then waits in its last cycle until the output register frees up.
`default_nettype none

module ntc_thermistor_temperature #(
  parameter int TABLE_DEPTH    = 100,
  parameter int ADC_FULL_SCALE = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ntc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ntc_pkg::ADC_W-1:0]         in_adc_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ntc_pkg::TEMP_W-1:0] out_temperature,
  output logic [ntc_pkg::RES_W-1:0]         out_resistance_ohms,
  output logic [ntc_pkg::ST_W-1:0]          out_status
);
  import ntc_pkg::*;

  ntc_cmd_t  cmd;
  ntc_stat_t stat;

  ntc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ntc_dp #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_adc_sample       (in_adc_sample),
    .cmd                 (cmd),
    .stat                (stat),
    .out_temperature     (out_temperature),
    .out_resistance_ohms (out_resistance_ohms),
    .out_status          (out_status)
  );

endmodule

`default_nettype wire

// File: rtl/ntc_dp.sv
// Datapath: config registers, multiplier, restoring divider, table search and result register.
`default_nettype none

module ntc_dp #(
  parameter int TABLE_DEPTH    = 100,
  parameter int ADC_FULL_SCALE = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ntc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic [ntc_pkg::ADC_W-1:0]             in_adc_sample,
  input  ntc_pkg::ntc_cmd_t                     cmd,
  output ntc_pkg::ntc_stat_t                    stat,
  output logic signed [ntc_pkg::TEMP_W-1:0]     out_temperature,
  output logic [ntc_pkg::RES_W-1:0]             out_resistance_ohms,
  output logic [ntc_pkg::ST_W-1:0]              out_status
);
  import ntc_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int DEN_W  = $clog2(ADC_FULL_SCALE + 1);
  localparam int PROD_W = RES_W + ADC_W;
  localparam logic [RES_W-1:0] T_FIRST = tbl_entry('0);
  localparam logic [RES_W-1:0] T_LAST  = tbl_entry(TBL_IDX_W'(TABLE_DEPTH - 1));

  // Configuration registers
  logic [RES_W-1:0]    ref_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [OFFSET_W-1:0] offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r    <= REF_RST;
      limit_r  <= LIMIT_RST;
      offset_r <= OFFSET_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_REFERENCE: ref_r    <= cfg_wdata;
        CFG_LIMIT:     limit_r  <= cfg_wdata[LIMIT_W-1:0];
        CFG_OFFSET:    offset_r <= cfg_wdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Working registers
  logic [ADC_W-1:0]  adc_r;
  logic [PROD_W-1:0] prod_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [RES_W-1:0]  res_r;   // dividend low bits, shifted out as quotient bits come in
  logic [ST_W-1:0]   st_r;
  logic [CNT_W-1:0]  left_r;
  logic [CNT_W-1:0]  hi_r;    // one past the right bound
  logic [IDX_W-1:0]  mid_r;
  logic              found_r;

  // Per-sample decisions
  logic [ADC_W-1:0] num_hi;
  logic [31:0]      den_full;
  logic             full_scale;
  logic             fault;
  logic             sat;
  assign num_hi     = prod_r[PROD_W-1:RES_W];
  assign den_full   = 32'(ADC_FULL_SCALE) - {{(32-ADC_W){1'b0}}, adc_r};
  assign full_scale = {{(32-ADC_W){1'b0}}, adc_r} >= 32'(ADC_FULL_SCALE);
  assign fault      = adc_r > limit_r;
  assign sat        = full_scale ||
                      ({{(32-ADC_W){1'b0}}, num_hi} >= {{(32-DEN_W){1'b0}}, den_r});

  // Divider step
  logic [DEN_W:0] rem_sh;
  logic           q_bit;
  assign rem_sh = {rem_r, res_r[RES_W-1]};
  assign q_bit  = rem_sh >= {1'b0, den_r};

  // Search probe
  logic [CNT_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid_calc;
  logic [RES_W-1:0]   entry;
  logic               searching;
  assign mid_sum   = {1'b0, left_r} + {1'b0, hi_r} - (CNT_W + 1)'(1);
  assign mid_calc  = IDX_W'(mid_sum >> 1);
  assign entry     = tbl_entry(TBL_IDX_W'(mid_calc));
  assign searching = (left_r < hi_r) && !found_r;

  assign stat.fault     = fault;
  assign stat.sat       = sat;
  assign stat.range_ok  = !(res_r > T_FIRST) && !(res_r < T_LAST);
  assign stat.srch_done = !searching;

  // Sample, product, divide and search
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      adc_r <= in_adc_sample;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(ref_r) * PROD_W'(adc_r);
      den_r  <= den_full[DEN_W-1:0];
      st_r   <= ST_OK;
    end
    if (cmd.prep) begin
      if (fault) begin
        st_r  <= ST_FAULT;
        res_r <= '0;
      end else if (sat) begin
        res_r <= RES_MAX;
      end else begin
        rem_r <= DEN_W'(num_hi);
        res_r <= prod_r[RES_W-1:0];
      end
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
      res_r <= {res_r[RES_W-2:0], q_bit};
    end
    if (cmd.range_chk) begin
      if (res_r > T_FIRST) begin
        st_r <= ST_BELOW;
      end else if (res_r < T_LAST) begin
        st_r <= ST_ABOVE;
      end
      left_r  <= '0;
      hi_r    <= CNT_W'(TABLE_DEPTH);
      mid_r   <= '0;
      found_r <= 1'b0;
    end
    if (cmd.probe && searching) begin
      mid_r <= mid_calc;
      if (res_r == entry) begin
        found_r <= 1'b1;
      end else if (res_r > entry) begin
        hi_r <= CNT_W'(mid_calc);
      end else begin
        left_r <= CNT_W'(mid_calc) + CNT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_resistance_ohms <= res_r;
      out_status          <= st_r;
      case (st_r)
        ST_FAULT: out_temperature <= TEMP_FAULT;
        ST_BELOW: out_temperature <= TEMP_BELOW;
        ST_ABOVE: out_temperature <= TEMP_ABOVE;
        default:  out_temperature <= TEMP_W'(mid_r) - TEMP_W'(offset_r);
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/ntc_ctrl.sv
// Controller: sequences multiply, divide, range check and search for one request.
`default_nettype none

module ntc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ntc_pkg::ntc_stat_t stat,
  output ntc_pkg::ntc_cmd_t  cmd
);
  import ntc_pkg::*;

  localparam int QUO_W   = RES_W;
  localparam int DCNT_W  = $clog2(QUO_W);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_PREP, S_DIV, S_RANGE, S_SRCH, S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              in_stall_r;
  logic              out_valid_r;
  logic              accept;
  logic              load;

  assign accept    = in_valid && !in_stall_r;
  assign load      = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.capture   = (state_r == S_IDLE) && accept;
    cmd.mul       = (state_r == S_MUL);
    cmd.prep      = (state_r == S_PREP);
    cmd.div_step  = (state_r == S_DIV);
    cmd.range_chk = (state_r == S_RANGE);
    cmd.probe     = (state_r == S_SRCH);
    cmd.load_out  = load;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_PREP;
      S_PREP: begin
        cnt_nxt = DCNT_W'(QUO_W - 1);
        if (stat.fault) begin
          state_nxt = S_FIN;
        end else if (stat.sat) begin
          state_nxt = S_RANGE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r - DCNT_W'(1);
        if (cnt_r == '0) state_nxt = S_RANGE;
      end
      S_RANGE: state_nxt = stat.range_ok ? S_SRCH : S_FIN;
      S_SRCH:  if (stat.srch_done) state_nxt = S_FIN;
      S_FIN:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      in_stall_r  <= (state_nxt != S_IDLE);
      out_valid_r <= load || (out_valid_r && out_stall);
    end
  end

endmodule

`default_nettype wire

// File: rtl/ntc_chk.sv
// Port-level assertions for the NTC temperature block, bound to the top level.
`default_nettype none

module ntc_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [ntc_pkg::TEMP_W-1:0] out_temperature,
  input logic [ntc_pkg::RES_W-1:0]         out_resistance_ohms,
  input logic [ntc_pkg::ST_W-1:0]          out_status
);
  import ntc_pkg::*;

  // Held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_temperature) &&
      $stable(out_resistance_ohms) && $stable(out_status))
    else $error("result changed while stalled");

  // Fault results carry the fault code and zero resistance
  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FAULT) |->
      (out_temperature == TEMP_FAULT) && (out_resistance_ohms == '0))
    else $error("bad fault result");

  // Out-of-range codes match their status
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BELOW || out_status == ST_ABOVE) |->
      (out_temperature == TEMP_BELOW && out_status == ST_BELOW) ||
      (out_temperature == TEMP_ABOVE && out_status == ST_ABOVE))
    else $error("range code mismatch");

  // Input side is open right after reset
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("stalled after reset");

  // A request occupies the block in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken back to back");

endmodule

bind ntc_thermistor_temperature ntc_chk u_chk (.*);

`default_nettype wire
